FILE: sv/predicted_obb_collision_check_core_defines.svh
// assertion macros for the predicted obb collision check core
// no dependencies; included by files that carry concurrent assertions
`ifndef PREDICTED_OBB_COLLISION_CHECK_CORE_DEFINES_SVH
`define PREDICTED_OBB_COLLISION_CHECK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define OBBC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obbc assertion failed (same cycle)");
`define OBBC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obbc assertion failed (next cycle)");
`else
`define OBBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define OBBC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/obbc_pkg.sv
// shared constants, register codes and arithmetic helpers for the obb check
// no dependencies
`timescale 1ns / 1ps
package obbc_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int NUM_STAGES  = 11;
  localparam int TRIG_STAGES = 6;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // q30 taylor coefficients of sin(pi/2 * x)
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598669;
  localparam logic [31:0] K5 = 32'd85569305;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;

  localparam logic [1:0] REG_EGO_LENGTH   = 2'd0;
  localparam logic [1:0] REG_EGO_WIDTH    = 2'd1;
  localparam logic [1:0] REG_SAFETY_MARGIN = 2'd2;
  localparam logic [1:0] REG_MARGIN_GROWTH = 2'd3;

  // 16-bit turn fraction to ANGLE_BITS phase
  function automatic logic [ANGLE_BITS-1:0] to_phase(input logic [15:0] a);
    logic [ANGLE_BITS+15:0] w;
    w = {a, {ANGLE_BITS{1'b0}}} >> 16;
    return w[ANGLE_BITS-1:0];
  endfunction

  // one horner step: k - (p * x2) >> 30
  function automatic logic [31:0] hstep(input logic [31:0] k, input logic [31:0] p,
                                        input logic [30:0] x2);
    logic [62:0] m;
    m = 63'(p) * 63'(x2);
    return k - m[61:30];
  endfunction

  // |a*b +/- c*d| rounded half up from q28 to q14
  function automatic logic [16:0] dot_abs(input logic signed [15:0] a,
                                          input logic signed [15:0] b,
                                          input logic signed [15:0] c,
                                          input logic signed [15:0] d,
                                          input logic neg);
    logic signed [32:0] pa;
    logic signed [32:0] pc;
    logic signed [32:0] acc;
    logic signed [18:0] q;
    pa = 33'(a) * 33'(b);
    pc = 33'(c) * 33'(d);
    acc = (neg ? pa - pc : pa + pc) + 33'sd8192;
    q = acc[32:14];
    return q[18] ? 17'(-q) : q[16:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: sv/predicted_obb_collision_check_core.sv
// predicted obb collision check core: top level, pipeline control, apb registers
// depends on obbc_pkg, obbc_qsin, obbc_sep_axis and the defines header
//
// usage: one transaction on the input channel (in_valid/in_ready) carries an
//   ego pose, an obstacle and a time offset; one transaction on the output
//   channel (out_valid/out_ready) returns the overlap flag for it, in order
// out_valid rises for a transaction once it has passed through every stage,
//   and the output transaction completes when the receiver is ready
// throughput: one transaction per cycle while out_ready is high; each stage
//   has a valid bit, loads when empty or its successor moves, so bubbles close
// the longest paths are the 32x31 horner multipliers of the sine units and the
//   34x17 radius products of the axis units, one per stage
// stall: when out_ready is low the output register holds; in_ready drops only
//   once every stage is full, nothing is lost or repeated
// reset: rst is synchronous; it empties the pipeline and loads the register
//   defaults (ego length 4.5 m, width 2 m, no margin, no growth)
// config: apb writes at byte 0, 4, 8, 12; only while the pipeline is idle
`timescale 1ns / 1ps
`include "predicted_obb_collision_check_core_defines.svh"
module predicted_obb_collision_check_core import obbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] ego_x,
  input  logic signed [31:0] ego_y,
  input  logic [15:0]        ego_yaw,
  input  logic signed [31:0] obs_x,
  input  logic signed [31:0] obs_y,
  input  logic [15:0]        obs_heading,
  input  logic signed [15:0] obs_speed,
  input  logic [15:0]        obs_length,
  input  logic [15:0]        obs_width,
  input  logic [15:0]        time_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               overlap
);

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [32:0] st;
    logic [33:0]        ehl;
    logic [33:0]        ehw;
    logic [22:0]        ohl;
    logic [22:0]        ohw;
  } side_t;

  // config registers
  logic [15:0] ego_length_r, ego_width_r, safety_margin_r, margin_growth_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ego_length_r <= 16'd1152;
      ego_width_r <= 16'd512;
      safety_margin_r <= 16'd0;
      margin_growth_r <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_EGO_LENGTH:    ego_length_r <= pwdata[15:0];
        REG_EGO_WIDTH:     ego_width_r <= pwdata[15:0];
        REG_SAFETY_MARGIN: safety_margin_r <= pwdata[15:0];
        REG_MARGIN_GROWTH: margin_growth_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EGO_LENGTH:    prdata = {16'd0, ego_length_r};
      REG_EGO_WIDTH:     prdata = {16'd0, ego_width_r};
      REG_SAFETY_MARGIN: prdata = {16'd0, safety_margin_r};
      REG_MARGIN_GROWTH: prdata = {16'd0, margin_growth_r};
      default:           prdata = 32'd0;
    endcase
  end

  // pipeline control: a stage moves when it is empty or its successor moves
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] adv;

  always_comb begin
    adv[NUM_STAGES] = !v[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];
  assign out_valid = v[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1 side terms: displacement scale, half sizes with margin
  side_t       side_in;
  logic [32:0] margin;

  always_comb begin
    margin = 33'({safety_margin_r, 8'd0}) + 33'(margin_growth_r) * 33'(time_offset);
    side_in.ex = ego_x;
    side_in.ey = ego_y;
    side_in.ox = obs_x;
    side_in.oy = obs_y;
    side_in.st = 33'(obs_speed) * $signed({17'd0, time_offset});
    side_in.ehl = 34'({ego_length_r, 7'd0}) + 34'(margin);
    side_in.ehw = 34'({ego_width_r, 7'd0}) + 34'(margin);
    side_in.ohl = {obs_length, 7'd0};
    side_in.ohw = {obs_width, 7'd0};
  end

  side_t side [1:TRIG_STAGES];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side[1] <= side_in;
    end
    for (int k = 2; k <= TRIG_STAGES; k++) begin
      if (adv[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // stages 1..6: four sine units (cos is sine a quarter turn ahead)
  logic [ANGLE_BITS-1:0] ego_ph, obs_ph;
  logic signed [15:0]    ec6, es6, oc6, os6;

  assign ego_ph = to_phase(ego_yaw);
  assign obs_ph = to_phase(obs_heading);

  obbc_qsin u_ego_sin (.clk(clk), .en(adv[TRIG_STAGES:1]), .phase(ego_ph), .val(es6));
  obbc_qsin u_ego_cos (.clk(clk), .en(adv[TRIG_STAGES:1]), .phase(ego_ph + QUARTER),
                       .val(ec6));
  obbc_qsin u_obs_sin (.clk(clk), .en(adv[TRIG_STAGES:1]), .phase(obs_ph), .val(os6));
  obbc_qsin u_obs_cos (.clk(clk), .en(adv[TRIG_STAGES:1]), .phase(obs_ph + QUARTER),
                       .val(oc6));

  // stage 7: obstacle displacement products
  side_t              side7;
  logic signed [15:0] ec7, es7, oc7, os7;
  logic signed [48:0] dispx7, dispy7;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      side7 <= side[TRIG_STAGES];
      ec7 <= ec6;
      es7 <= es6;
      oc7 <= oc6;
      os7 <= os6;
      dispx7 <= 49'(side[TRIG_STAGES].st) * 49'(oc6);
      dispy7 <= 49'(side[TRIG_STAGES].st) * 49'(os6);
    end
  end

  // stage 8: predicted centre with rounding and saturation, centre difference
  logic signed [48:0] rndx, rndy;
  logic signed [31:0] ocx, ocy;
  logic signed [32:0] dx8, dy8;
  logic signed [15:0] ec8, es8, oc8, os8, nes8, nos8;
  logic [33:0]        ehl8, ehw8;
  logic [22:0]        ohl8, ohw8;

  always_comb begin
    rndx = dispx7 + 49'sd8192;
    rndy = dispy7 + 49'sd8192;
    ocx = sat32(36'(side7.ox) + 36'($signed(rndx[48:14])));
    ocy = sat32(36'(side7.oy) + 36'($signed(rndy[48:14])));
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      dx8 <= 33'(ocx) - 33'(side7.ex);
      dy8 <= 33'(ocy) - 33'(side7.ey);
      ec8 <= ec7;
      es8 <= es7;
      oc8 <= oc7;
      os8 <= os7;
      nes8 <= -es7;
      nos8 <= -os7;
      ehl8 <= side7.ehl;
      ehw8 <= side7.ehw;
      ohl8 <= side7.ohl;
      ohw8 <= side7.ohw;
    end
  end

  // stages 9..11: the four box axes in parallel
  logic [3:0] sep;

  obbc_sep_axis u_ax0 (.clk(clk), .en(adv[11:9]), .dx(dx8), .dy(dy8), .lx(ec8), .ly(es8),
    .ec(ec8), .es(es8), .oc(oc8), .os(os8), .ehl(ehl8), .ehw(ehw8), .ohl(ohl8),
    .ohw(ohw8), .sep(sep[0]));
  obbc_sep_axis u_ax1 (.clk(clk), .en(adv[11:9]), .dx(dx8), .dy(dy8), .lx(nes8), .ly(ec8),
    .ec(ec8), .es(es8), .oc(oc8), .os(os8), .ehl(ehl8), .ehw(ehw8), .ohl(ohl8),
    .ohw(ohw8), .sep(sep[1]));
  obbc_sep_axis u_ax2 (.clk(clk), .en(adv[11:9]), .dx(dx8), .dy(dy8), .lx(oc8), .ly(os8),
    .ec(ec8), .es(es8), .oc(oc8), .os(os8), .ehl(ehl8), .ehw(ehw8), .ohl(ohl8),
    .ohw(ohw8), .sep(sep[2]));
  obbc_sep_axis u_ax3 (.clk(clk), .en(adv[11:9]), .dx(dx8), .dy(dy8), .lx(nos8), .ly(oc8),
    .ec(ec8), .es(es8), .oc(oc8), .os(os8), .ehl(ehl8), .ehw(ehw8), .ohl(ohl8),
    .ohw(ohw8), .sep(sep[3]));

  // overlap unless some axis separates the boxes
  assign overlap = ~|sep;

  // an empty output stage always frees the whole pipe
  `OBBC_ASSERT_IMP(a_ready_when_out_empty, clk, rst, !out_valid, in_ready)
  // a ready receiver always lets a new transaction in
  `OBBC_ASSERT_IMP(a_ready_follows_out, clk, rst, out_ready, in_ready)
  // a blocked first stage keeps its item
  `OBBC_ASSERT_NXT(a_first_stage_holds, clk, rst, v[1] && !adv[1], v[1])

endmodule

FILE: sv/obbc_qsin.sv
// pipelined q1.14 sine of a turn-fraction phase, degree-9 horner polynomial
// depends on obbc_pkg
`timescale 1ns / 1ps
module obbc_qsin import obbc_pkg::*; (
  input  logic                   clk,
  input  logic [TRIG_STAGES-1:0] en,
  input  logic [ANGLE_BITS-1:0]  phase,
  output logic signed [15:0]     val
);

  logic [1:0]  quad_in;
  logic [29:0] xf;
  logic [30:0] x_in;
  logic [61:0] sq;
  logic [62:0] fin;
  logic [32:0] rsum;
  logic [16:0] r;

  logic [30:0] xs  [1:5];
  logic [1:0]  qs  [1:5];
  logic [30:0] x2s [1:4];
  logic [31:0] ps  [2:5];

  always_comb begin
    quad_in = phase[ANGLE_BITS-1 -: 2];
    xf = {phase[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    // odd quadrants mirror the fraction
    x_in = quad_in[0] ? (31'd1 << 30) - {1'b0, xf} : {1'b0, xf};
    sq = 62'(x_in) * 62'(x_in);
    fin = 63'(ps[5]) * 63'(xs[5]);
    rsum = {1'b0, fin[61:30]} + 33'd32768;
    r = (rsum[32:16] > 17'd16384) ? 17'd16384 : rsum[32:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xs[1] <= x_in;
      qs[1] <= quad_in;
      x2s[1] <= sq[60:30];
    end
    if (en[1]) begin
      xs[2] <= xs[1];
      qs[2] <= qs[1];
      x2s[2] <= x2s[1];
      ps[2] <= hstep(K7, K9, x2s[1]);
    end
    if (en[2]) begin
      xs[3] <= xs[2];
      qs[3] <= qs[2];
      x2s[3] <= x2s[2];
      ps[3] <= hstep(K5, ps[2], x2s[2]);
    end
    if (en[3]) begin
      xs[4] <= xs[3];
      qs[4] <= qs[3];
      x2s[4] <= x2s[3];
      ps[4] <= hstep(K3, ps[3], x2s[3]);
    end
    if (en[4]) begin
      xs[5] <= xs[4];
      qs[5] <= qs[4];
      ps[5] <= hstep(K1, ps[4], x2s[4]);
    end
    if (en[5]) begin
      val <= qs[5][1] ? -$signed({1'b0, r[14:0]}) - ((r[16:15] != 2'b00) ? 16'sd0 : 16'sd0)
                      : $signed({1'b0, r[14:0]});
    end
  end

endmodule

FILE: sv/obbc_sep_axis.sv
// three-stage separating axis test of two boxes on one axis
// depends on obbc_pkg
`timescale 1ns / 1ps
module obbc_sep_axis import obbc_pkg::*; (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  input  logic signed [15:0] lx,
  input  logic signed [15:0] ly,
  input  logic signed [15:0] ec,
  input  logic signed [15:0] es,
  input  logic signed [15:0] oc,
  input  logic signed [15:0] os,
  input  logic [33:0]        ehl,
  input  logic [33:0]        ehw,
  input  logic [22:0]        ohl,
  input  logic [22:0]        ohw,
  output logic               sep
);

  logic [16:0]        edl, edw, odl, odw;
  logic signed [48:0] px, py;
  logic [33:0]        ehl_a, ehw_a;
  logic [22:0]        ohl_a, ohw_a;
  logic [50:0]        re_l, re_w;
  logic [39:0]        ro_l, ro_w;
  logic [49:0]        proj;
  logic signed [49:0] psum;
  logic [52:0]        rad;

  always_comb begin
    psum = 50'(px) + 50'(py);
    rad = 53'(re_l) + 53'(re_w) + 53'(ro_l) + 53'(ro_w);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      edl <= dot_abs(ec, lx, es, ly, 1'b0);
      edw <= dot_abs(ec, ly, es, lx, 1'b1);
      odl <= dot_abs(oc, lx, os, ly, 1'b0);
      odw <= dot_abs(oc, ly, os, lx, 1'b1);
      px <= 49'(dx) * 49'(lx);
      py <= 49'(dy) * 49'(ly);
      ehl_a <= ehl;
      ehw_a <= ehw;
      ohl_a <= ohl;
      ohw_a <= ohw;
    end
    if (en[1]) begin
      re_l <= 51'(ehl_a) * 51'(edl);
      re_w <= 51'(ehw_a) * 51'(edw);
      ro_l <= 40'(ohl_a) * 40'(odl);
      ro_w <= 40'(ohw_a) * 40'(odw);
      proj <= psum[49] ? 50'(-psum) : 50'(psum);
    end
    if (en[2]) begin
      // touching counts as overlap
      sep <= 53'(proj) > rad;
    end
  end

endmodule

FILE: tb/tb_top.sv
// testbench for the predicted obb collision check core: directed and random pose/obstacle pairs
// depends on obbc_pkg and predicted_obb_collision_check_core; overlap flags predicted in-bench
`timescale 1ns / 1ps
module tb_top;
  import obbc_pkg::*;

  // overlap scoreboard: predicts one flag per accepted pair, checks results in order
  class overlap_scoreboard;
    bit          pending_flags[$];
    int unsigned mismatches;
    logic [15:0] len_q88, wid_q88, margin_q88, growth_q88;

    function new();
      mismatches = 0;
      len_q88 = 16'd1152;
      wid_q88 = 16'd512;
      margin_q88 = 16'd0;
      growth_q88 = 16'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_EGO_LENGTH: len_q88 = val;
        REG_EGO_WIDTH: wid_q88 = val;
        REG_SAFETY_MARGIN: margin_q88 = val;
        default: growth_q88 = val;
      endcase
    endfunction

    // floor((v + 2^(s-1)) / 2^s)
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // q1.14 sine of a 16-bit turn fraction (taylor degree 9)
    function longint sine_q14(logic [15:0] ph);
      logic [1:0]  quad;
      logic [63:0] x, x2, p, s, r;
      quad = ph[15:14];
      x = 64'(ph[13:0]) << 16;
      if (quad[0]) x = (64'd1 << 30) - x;
      x2 = (x * x) >> 30;
      p = 64'(K9);
      p = 64'(K7) - ((p * x2) >> 30);
      p = 64'(K5) - ((p * x2) >> 30);
      p = 64'(K3) - ((p * x2) >> 30);
      p = 64'(K1) - ((p * x2) >> 30);
      s = (p * x) >> 30;
      r = (s + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      return quad[1] ? -longint'(r) : longint'(r);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint abs_l(longint v);
      return v < 0 ? -v : v;
    endfunction

    // projected half extent of a box onto axis (lx, ly), q30
    function longint box_radius(longint c, longint s, longint hl, longint hw,
                                longint lx, longint ly);
      longint dl, dw;
      dl = round_shift(c * lx + s * ly, 14);
      dw = round_shift(-s * lx + c * ly, 14);
      return hl * abs_l(dl) + hw * abs_l(dw);
    endfunction

    function bit predict(logic signed [31:0] ex, ey, logic [15:0] eyaw,
                         logic signed [31:0] ox, oy, logic [15:0] ohd,
                         logic signed [15:0] spd, logic [15:0] olen, owid, tofs);
      longint ec, es, oc, os, ehl, ehw, ohl, ohw, ocx, ocy, dx, dy, st, m;
      longint ax[4], ay[4];
      bit hit;
      m = longint'(margin_q88) * 256 + longint'(growth_q88) * longint'(tofs);
      es = sine_q14(eyaw);
      ec = sine_q14(eyaw + QUARTER);
      os = sine_q14(ohd);
      oc = sine_q14(ohd + QUARTER);
      ehl = longint'(len_q88) * 128 + m;
      ehw = longint'(wid_q88) * 128 + m;
      ohl = longint'(olen) * 128;
      ohw = longint'(owid) * 128;
      st = longint'(spd) * longint'(tofs);
      ocx = clamp32(longint'(ox) + round_shift(st * oc, 14));
      ocy = clamp32(longint'(oy) + round_shift(st * os, 14));
      dx = ocx - longint'(ex);
      dy = ocy - longint'(ey);
      ax = '{ec, -es, oc, -os};
      ay = '{es, ec, os, oc};
      hit = 1'b1;
      for (int k = 0; k < 4; k++) begin
        // touching counts as overlap, so strict compare
        if (abs_l(dx * ax[k] + dy * ay[k]) >
            box_radius(ec, es, ehl, ehw, ax[k], ay[k]) +
            box_radius(oc, os, ohl, ohw, ax[k], ay[k]))
          hit = 1'b0;
      end
      return hit;
    endfunction

    function void note_pair(bit flag);
      pending_flags.push_back(flag);
    endfunction

    function void check_flag(bit got);
      bit want;
      if (pending_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result overlap=%0b", got);
        return;
      end
      want = pending_flags.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("overlap mismatch: expected %0b actual %0b", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] ego_x = '0, ego_y = '0, obs_x = '0, obs_y = '0;
  logic [15:0] ego_yaw = '0, obs_heading = '0, obs_length = '0, obs_width = '0;
  logic [15:0] time_offset = '0;
  logic signed [15:0] obs_speed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic overlap;

  overlap_scoreboard board = new();
  bit stall_hold = 1'b0;   // forces the receiver off for a long stretch
  bit load_done = 1'b0;

  always #5 clk = ~clk;

  predicted_obb_collision_check_core DUT (.*);

  // register write: setup cycle then access cycle
  task automatic apb_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] l, w, m, g);
    apb_write(REG_EGO_LENGTH, l);
    apb_write(REG_EGO_WIDTH, w);
    apb_write(REG_SAFETY_MARGIN, m);
    apb_write(REG_MARGIN_GROWTH, g);
  endtask

  // offer one pair, hold it until accepted; called at a falling edge
  task automatic send_pair(logic signed [31:0] ex, ey, logic [15:0] eyaw,
                           logic signed [31:0] ox, oy, logic [15:0] ohd,
                           logic signed [15:0] spd, logic [15:0] olen, owid, tofs);
    ego_x <= ex; ego_y <= ey; ego_yaw <= eyaw;
    obs_x <= ox; obs_y <= oy; obs_heading <= ohd;
    obs_speed <= spd; obs_length <= olen; obs_width <= owid; time_offset <= tofs;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_pair(board.predict(ex, ey, eyaw, ox, oy, ohd, spd, olen, owid, tofs));
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // random pair: mostly near-miss geometry so both outcomes show up
  task automatic random_pair();
    logic signed [31:0] ex, ey, ox, oy;
    logic [15:0] olen, owid, tofs;
    logic signed [15:0] spd;
    int mode;
    mode = $urandom_range(0, 9);
    ex = $urandom;
    ey = $urandom;
    if (mode < 7) begin
      // obstacle within a few box lengths of the ego
      ox = ex + $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      oy = ey + $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      olen = 16'($urandom_range(0, 2048));
      owid = 16'($urandom_range(0, 1024));
      spd = $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
      tofs = 16'($urandom_range(0, 1024));
    end else begin
      ox = $urandom;
      oy = $urandom;
      olen = 16'($urandom);
      owid = 16'($urandom);
      spd = 16'($urandom);
      tofs = 16'($urandom);
    end
    send_pair(ex, ey, 16'($urandom), ox, oy, 16'($urandom), spd, olen, owid, tofs);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_flags.size() != 0) @(negedge clk);
    repeat (NUM_STAGES + 4) @(negedge clk);
  endtask

  // receiver: own stall pattern, plus the long hold-off on request
  always @(negedge clk) begin
    if (rst || stall_hold) begin
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 3))
        0: out_ready <= ($urandom_range(0, 3) != 0);
        1: out_ready <= 1'b1;
        default: out_ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_flag(overlap);
  end

  // long hold-off while the sender keeps streaming, so the pipeline fills
  initial begin
    wait (load_done);
    @(negedge clk);
    stall_hold = 1'b1;
    repeat (60) @(negedge clk);
    stall_hold = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, touching, degenerate sizes, saturation
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 32'sd3 << 16, 0, 0, 0, 16'd512, 16'd256, 0);   // overlapping in x
    send_pair(0, 0, 0, 32'sd4 << 16, 0, 0, 0, 16'd256, 16'd256, 0);   // apart in x
    send_pair(0, 0, 16'h4000, 0, 32'sd3 << 16, 16'h8000, 0, 512, 512, 0);
    send_pair(32'sh7fffffff, 32'sh7fffffff, 16'hffff, 32'sh7fffffff, 32'sh7fffffff,
              16'h0000, 16'sh7fff, 16'hffff, 16'hffff, 16'hffff);   // saturate high
    send_pair(32'sh80000000, 32'sh80000000, 16'h2000, 32'sh80000000, 32'sh80000000,
              16'h0000, 16'sh8000, 16'hffff, 16'hffff, 16'hffff);   // saturate low
    send_pair(32'sh80000000, 32'sh7fffffff, 16'h1234, 32'sh7fffffff, 32'sh80000000,
              16'hc000, 16'sh8000, 0, 0, 16'hffff);
    send_pair(0, 0, 16'h2000, 32'sd1 << 16, 32'sd1 << 16, 16'h6000, 16'sd256, 0, 16'd1024,
              16'd256);
    send_pair(0, 0, 16'h8000, 0, 0, 16'h4000, -16'sd256, 16'hffff, 0, 16'h0100);
    send_pair(32'sd100, -32'sd100, 16'h0001, 32'sd200, 32'sd5, 16'hfffe, 16'sd1, 1, 1, 1);
    drain();

    set_all(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_pair(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff);
    send_pair(0, 0, 16'h3000, 32'sd1000 << 16, 0, 0, 0, 0, 0, 16'hffff);
    drain();
    set_all(0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);   // point vs point
    send_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    drain();
    set_all(16'd1152, 16'd512, 16'd64, 16'd128);

    // random bursts; one long receiver hold-off in the first phase
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 150;) begin
        int burst;
        burst = $urandom_range(1, 20);
        if (phase == 0 && n >= 20) load_done = 1'b1;
        for (int b = 0; b < burst && n < 150; b++, n++) random_pair();
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      drain();
      if (phase == 0) set_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 512)),
                              16'($urandom_range(0, 512)));
      else if (phase == 1) set_all(16'd1152, 16'd512, 16'd0, 16'd0);
    end

    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
